// ===== sv/assert_macros.svh =====
// Assertion macros used by the recency list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low reset).
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== sv/lrl_pkg.sv =====
// Package for the LRU recency list: sizes, action codes and cell command type.
package lrl_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 8;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_BUMP = 2'd1,
    ACT_DEL  = 2'd2
  } action_e;

  // Command broadcast to every cell in the row
  typedef struct packed {
    logic             push;   // shift every cell one place towards the tail
    logic             bump;   // shift cells up to and including the first hit
    logic             del;    // close the gap from the first hit to the tail
    logic [KEY_W-1:0] key;    // search key
  } cell_cmd_t;

endpackage

// ===== sv/lrl_cell.sv =====
// One position of the recency list: key register, match and shift selection.
module lrl_cell (
  input  logic                                clk_i,
  input  lrl_pkg::cell_cmd_t                  cmd_i,
  input  logic                                occ_i,       // position holds a key
  input  logic [lrl_pkg::KEY_W-1:0]           left_key_i,  // neighbour towards the head
  input  logic [lrl_pkg::KEY_W-1:0]           right_key_i, // neighbour towards the tail
  input  logic                                seen_i,      // hit in a cell nearer the head
  output logic [lrl_pkg::KEY_W-1:0]           key_o,
  output logic                                seen_o
);

  logic [lrl_pkg::KEY_W-1:0] key_q, key_d;

  // first-match ripple along the row
  assign seen_o = seen_i | (occ_i & (key_q == cmd_i.key));

  // next key: take from the left on push/bump, from the right on delete
  always_comb begin
    key_d = key_q;
    if (cmd_i.push) begin
      key_d = left_key_i;
    end else if (cmd_i.bump && !seen_i) begin
      key_d = left_key_i;
    end else if (cmd_i.del && seen_o) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== sv/lru_recency_list.sv =====
// LRU recency list top level: row of key cells, count, capacity and result register.
// Result: registered, on m_axis in the cycle after the input transfer.
// Throughput: one transfer per cycle unless m_axis stalls; the first-match ripple
// through the DEPTH cells and the shift of the row both complete within that cycle.
// Reset: key count cleared and capacity set to DEPTH; key cells are not reset
// and need no clearing pass, so the block accepts input straight after reset.
`include "assert_macros.svh"

module lru_recency_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: capacity register
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] accepted, [1] found, [2] evicted_valid,
                                      // [10:3] evicted_key, [15:11] occupancy
);

  localparam int unsigned N = lrl_pkg::DEPTH;

  logic [lrl_pkg::CNT_W-1:0] count_q, count_d;
  logic [lrl_pkg::CNT_W-1:0] cap_q;
  logic [lrl_pkg::CNT_W-1:0] cnt_m1;
  logic [lrl_pkg::IDX_W-1:0] tail_idx;

  logic [N-1:0]              occ;
  logic [N:0]                seen;
  logic [lrl_pkg::KEY_W-1:0] keys [N];

  lrl_pkg::cell_cmd_t cmd;
  lrl_pkg::action_e   action;
  logic               s_fire;
  logic               found;
  logic               is_add, add_ok, evict;

  // result register
  logic                      res_valid_q;
  logic                      res_acc_q, res_found_q, res_ev_q;
  logic [lrl_pkg::KEY_W-1:0] res_ev_key_q;
  logic [lrl_pkg::CNT_W-1:0] res_occ_q;

  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign action        = lrl_pkg::action_e'(s_axis_tuser);

  // decode
  assign is_add = s_fire && (action == lrl_pkg::ACT_ADD);
  assign add_ok = is_add && (cap_q != '0);
  assign evict  = add_ok && (count_q >= cap_q);
  assign found  = seen[N];

  assign cmd.push = add_ok;
  assign cmd.bump = s_fire && (action == lrl_pkg::ACT_BUMP) && found;
  assign cmd.del  = s_fire && (action == lrl_pkg::ACT_DEL) && found;
  assign cmd.key  = s_axis_tdata;

  // tail key for eviction
  assign cnt_m1   = count_q - lrl_pkg::CNT_W'(1);
  assign tail_idx = cnt_m1[lrl_pkg::IDX_W-1:0];

  // row of cells
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [lrl_pkg::KEY_W-1:0] left_key, right_key;
    assign occ[i]    = (lrl_pkg::CNT_W'(i) < count_q);
    assign left_key  = (i == 0) ? s_axis_tdata : keys[(i == 0) ? 0 : i - 1];
    assign right_key = (i == N - 1) ? keys[i] : keys[(i == N - 1) ? i : i + 1];

    lrl_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occ_i       (occ[i]),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .seen_i      (seen[i]),
      .key_o       (keys[i]),
      .seen_o      (seen[i+1])
    );
  end

  // key count
  always_comb begin
    count_d = count_q;
    if (add_ok && !evict) begin
      count_d = count_q + lrl_pkg::CNT_W'(1);
    end else if (cmd.del) begin
      count_d = cnt_m1;
    end
  end

  // control and capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= lrl_pkg::CNT_W'(lrl_pkg::DEPTH);
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        if (lrl_pkg::CNT_W'(cfg_wdata_i) > lrl_pkg::CNT_W'(lrl_pkg::DEPTH)) begin
          cap_q <= lrl_pkg::CNT_W'(lrl_pkg::DEPTH);
        end else begin
          cap_q <= lrl_pkg::CNT_W'(cfg_wdata_i);
        end
      end
      if (s_fire) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_acc_q    <= add_ok;
      res_found_q  <= (cmd.bump || cmd.del);
      res_ev_q     <= evict;
      res_ev_key_q <= evict ? keys[tail_idx] : '0;
      res_occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {res_occ_q, res_ev_key_q, res_ev_q, res_found_q, res_acc_q};

  // checks
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= lrl_pkg::CNT_W'(lrl_pkg::DEPTH))
  `ASSERT_CLK(a_fire_gives_result, clk_i, rst_ni, s_fire |=> m_axis_tvalid)
  `ASSERT_CLK(a_count_idle, clk_i, rst_ni, !s_fire |=> $stable(count_q))
  `ASSERT_CLK(a_evict_accepted, clk_i, rst_ni, (res_valid_q && res_ev_q) |-> res_acc_q)

endmodule

// ===== tb/lru_recency_list_tb.sv =====
// Self-checking testbench for the LRU recency list: directed and random access streams.
module lru_recency_list_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 4;
  // action code the block leaves without effect
  localparam logic [1:0]  ACT_NONE    = 2'd3;

  // result word, laid out as on m_axis_tdata (accepted in bit 0)
  typedef struct packed {
    logic [4:0]                occupancy;
    logic [lrl_pkg::KEY_W-1:0] evicted_key;
    logic                      evicted_valid;
    logic                      found;
    logic                      accepted;
  } lru_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [4:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] key
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] accepted, [1] found, [2] evicted_valid,
                                     // [10:3] evicted_key, [15:11] occupancy

  // shadow copy of the recency list
  logic [lrl_pkg::KEY_W-1:0] shadow_keys [lrl_pkg::DEPTH];
  int unsigned      shadow_count    = 0;
  int unsigned      shadow_capacity = lrl_pkg::DEPTH;

  lru_result_t      pending_results [$];
  int unsigned      mismatch_count  = 0;
  int unsigned      cycle_count     = 0;
  bit               gaps_on         = 1'b1;
  int unsigned      hold_request    = 0;
  logic [7:0]       key_base        = 8'h00;

  lru_recency_list DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Apply one access to the shadow list and return the result it should give
  function automatic lru_result_t lru_update(input logic [1:0] act, input logic [7:0] k);
    lru_result_t r;
    int          hit;
    r   = '0;
    hit = -1;
    case (act)
      lrl_pkg::ACT_ADD: begin
        if (shadow_capacity != 0) begin
          r.accepted = 1'b1;
          if (shadow_count + 1 > shadow_capacity) begin
            // full: tail drops out, count unchanged
            r.evicted_valid = 1'b1;
            r.evicted_key   = shadow_keys[shadow_count-1];
            for (int i = shadow_count - 1; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
          end else begin
            for (int i = shadow_count; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_count++;
          end
          shadow_keys[0] = k;
        end
      end
      lrl_pkg::ACT_BUMP, lrl_pkg::ACT_DEL: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_keys[i] == k) hit = i;
        end
        if (hit >= 0) begin
          r.found = 1'b1;
          if (act == lrl_pkg::ACT_BUMP) begin
            for (int i = hit; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[0] = k;
          end else begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int exp_v, input int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, exp_v, got_v);
    mismatch_count++;
  endtask

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk_i) begin
    lru_result_t got;
    lru_result_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) begin
        shadow_capacity = (cfg_wdata_i > lrl_pkg::DEPTH) ? lrl_pkg::DEPTH : cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(lru_update(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = lru_result_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result transfer", 0, 1);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.accepted !== exp_r.accepted)
            report_mismatch("accepted", exp_r.accepted, got.accepted);
          if (got.found !== exp_r.found)
            report_mismatch("found", exp_r.found, got.found);
          if (got.evicted_valid !== exp_r.evicted_valid)
            report_mismatch("evicted_valid", exp_r.evicted_valid, got.evicted_valid);
          if (got.evicted_key !== exp_r.evicted_key)
            report_mismatch("evicted_key", exp_r.evicted_key, got.evicted_key);
          if (got.occupancy !== exp_r.occupancy)
            report_mismatch("occupancy", exp_r.occupancy, got.occupancy);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold when one is requested
  always @(negedge clk_i) begin
    static int unsigned hold_left = 0;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 23);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one access and hold it until the block takes it
  task automatic send_access(input logic [1:0] act, input logic [7:0] k);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [4:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [1:0] pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return lrl_pkg::ACT_ADD;
    if (r < 70) return lrl_pkg::ACT_BUMP;
    if (r < 95) return lrl_pkg::ACT_DEL;
    return ACT_NONE;
  endfunction

  // keys mostly from a small pool so bumps and deletes hit
  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_base ^ 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Each action on an empty and a small list, duplicates, head and tail bumps
  task automatic test_basic_ops();
    send_access(lrl_pkg::ACT_BUMP, 8'h3C);
    send_access(lrl_pkg::ACT_DEL,  8'h3C);
    send_access(ACT_NONE,          8'hFF);
    send_access(lrl_pkg::ACT_ADD,  8'h00);
    send_access(lrl_pkg::ACT_ADD,  8'hFF);
    send_access(lrl_pkg::ACT_ADD,  8'h5A);
    send_access(lrl_pkg::ACT_ADD,  8'hA5);
    send_access(lrl_pkg::ACT_ADD,  8'h5A);
    send_access(lrl_pkg::ACT_BUMP, 8'h5A);
    send_access(lrl_pkg::ACT_BUMP, 8'h00);
    send_access(lrl_pkg::ACT_BUMP, 8'hFF);
    send_access(lrl_pkg::ACT_DEL,  8'h5A);
    send_access(lrl_pkg::ACT_DEL,  8'h77);
    send_access(ACT_NONE,          8'h00);
    send_access(lrl_pkg::ACT_DEL,  8'h5A);
  endtask

  // Zero capacity, saturation, eviction and capacity dropped below the count
  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_access(lrl_pkg::ACT_ADD,  8'h11);
    send_access(lrl_pkg::ACT_BUMP, 8'hA5);
    send_access(lrl_pkg::ACT_DEL,  8'hA5);
    set_capacity(5'd31);
    for (int i = 0; i < lrl_pkg::DEPTH + 1; i++) send_access(lrl_pkg::ACT_ADD, 8'(8'h80 + i));
    set_capacity(5'd4);
    send_access(lrl_pkg::ACT_ADD, 8'h42);
    send_access(lrl_pkg::ACT_DEL, 8'h42);
    set_capacity(5'd1);
    send_access(lrl_pkg::ACT_ADD, 8'h24);
    send_access(lrl_pkg::ACT_ADD, 8'h25);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    set_capacity(5'd8);
    gaps_on      = 1'b0;
    hold_request = 80;
    for (int i = 0; i < 40; i++) send_access(pick_action(), pick_key());
    gaps_on = 1'b1;
  endtask

  // Full-rate burst with no idling on either side
  task automatic test_random_burst();
    set_capacity(5'(lrl_pkg::DEPTH));
    gaps_on  = 1'b0;
    key_base = 8'($urandom_range(0, 255));
    for (int i = 0; i < 250; i++) send_access(pick_action(), pick_key());
    gaps_on = 1'b1;
  endtask

  // Random phases over a spread of capacity settings
  task automatic test_random_phases();
    logic [4:0] cap;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       cap = 5'd1;
        1:       cap = 5'd2;
        2:       cap = 5'd31;
        3:       cap = 5'd0;
        4:       cap = 5'(lrl_pkg::DEPTH);
        default: cap = 5'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      key_base = 8'($urandom_range(0, 255));
      for (int i = 0; i < 160; i++) send_access(pick_action(), pick_key());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_capacity_limits();
    test_back_pressure();
    test_random_burst();
    test_random_phases();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lrl_pkg.sv
sv/lrl_cell.sv
sv/lru_recency_list.sv
tb/lru_recency_list_tb.sv
